### hw/rtl/vsp_pkg.sv
// ============================================================================
// vsp_pkg - shared types and constants for the version string parser
// Transaction payloads, parse section codes, error codes and character
// constants.
// ============================================================================
package vsp_pkg;

    // Input transaction: one character of the string, final one flagged
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_item;

    // Result transaction: packed version word and status
    typedef struct packed {
        logic [35:0] packed_version;
        logic [2:0]  error_code;
    } t_out_item;

    // Parse sections
    localparam logic [1:0] SEC_MAJOR = 2'd0;
    localparam logic [1:0] SEC_MINOR = 2'd1;
    localparam logic [1:0] SEC_FIX   = 2'd2;
    localparam logic [1:0] SEC_PATCH = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_OVER_LIMIT = 3'd1;
    localparam logic [2:0] ERR_MANY_DOTS  = 3'd2;
    localparam logic [2:0] ERR_MISSING    = 3'd3;
    localparam logic [2:0] ERR_BAD_PATCH  = 3'd4;
    localparam logic [2:0] ERR_NOT_LETTER = 3'd5;
    localparam logic [2:0] ERR_TOO_SHORT  = 3'd6;
    localparam logic [2:0] ERR_OVER_BYTE  = 3'd7;

    // Character constants
    localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_NINE        = 8'h39;
    localparam logic [7:0] CH_DOT         = 8'h2E;
    localparam logic [7:0] CH_LOWER_A     = 8'h61;
    localparam logic [7:0] CH_LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_FOLD_BIT  = 8'h20;

    // Packing
    localparam int unsigned BYTE_MAX   = 255;
    localparam logic [3:0]  RELEASE_ID = 4'hF;

endpackage

### hw/rtl/version_string_parser.sv
// ============================================================================
// version_string_parser - streaming version string decoder
// Parses major.minor.fix[letter] one character per cycle into a packed word.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one character
//   per transaction; last_byte marks the end of the string. Only the final
//   character produces a result transaction on the output channel
//   (o_out_valid / i_out_ready / o_out_data): the packed version word with
//   error_code 0, or a zero word and the first error seen.
//   Latency: the result appears in the cycle after the final character is
//   accepted. Throughput: one character per cycle; each character passes
//   through one level of parse logic (a multiply-by-ten add and compare)
//   into the parse state and result register.
//   Stall: the result register holds while the receiver is stalled; input
//   is still taken whenever the result register is empty or is being
//   drained in the same cycle, so back-to-back strings keep full rate.
//   Reset clears the parse state and drops any pending result. After each
//   final character the parse state returns to its reset values for the
//   next string.
// ============================================================================
module version_string_parser #(
    parameter int unsigned COMPONENT_LIMIT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  vsp_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output vsp_pkg::t_out_item    o_out_data
);
    import vsp_pkg::*;

    // Accumulators hold values up to the component limit
    localparam int unsigned ACC_W = $clog2(COMPONENT_LIMIT + 1);

    // Parse state
    logic [1:0]            r_section, n_section;
    logic [2:0][ACC_W-1:0] r_acc, n_acc;
    logic [4:0]            r_patch, n_patch;
    logic                  r_stopped, n_stopped;
    logic [2:0]            r_error, n_error;

    // Result register
    logic                  r_out_valid;
    t_out_item             r_out_data;

    t_out_item             step_result;
    logic                  in_accept;
    logic                  out_accept;

    // Accept while the result slot is free or draining this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_accept  = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    vsp_byte_step #(
        .COMPONENT_LIMIT (COMPONENT_LIMIT),
        .ACC_W           (ACC_W)
    ) u_step (
        .i_char    (i_in_data.char_byte),
        .i_section (r_section),
        .i_acc     (r_acc),
        .i_patch   (r_patch),
        .i_stopped (r_stopped),
        .i_error   (r_error),
        .o_section (n_section),
        .o_acc     (n_acc),
        .o_patch   (n_patch),
        .o_stopped (n_stopped),
        .o_error   (n_error),
        .o_result  (step_result)
    );

    // Advance parse state per character; clear it after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= SEC_MAJOR;
            r_acc     <= '0;
            r_patch   <= '0;
            r_stopped <= 1'b0;
            r_error   <= ERR_OK;
        end else if (in_accept) begin
            if (i_in_data.last_byte) begin
                r_section <= SEC_MAJOR;
                r_acc     <= '0;
                r_patch   <= '0;
                r_stopped <= 1'b0;
                r_error   <= ERR_OK;
            end else begin
                r_section <= n_section;
                r_acc     <= n_acc;
                r_patch   <= n_patch;
                r_stopped <= n_stopped;
                r_error   <= n_error;
            end
        end
    end

    // Load the result on the final character; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.last_byte) begin
            r_out_data <= step_result;
        end
    end

`ifndef NO_ASSERTIONS
    // A drained result with no new final character leaves the slot empty
    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && !(in_accept && i_in_data.last_byte)) |=> !r_out_valid)
        else $error("result slot not emptied after drain");

    // An error result carries a zero word
    a_error_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.error_code != ERR_OK)
            |-> (r_out_data.packed_version == '0))
        else $error("error result with nonzero version word");

    // A good result carries the release nibble and a patch level of at most 26
    a_ok_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.error_code == ERR_OK)
            |-> (r_out_data.packed_version[3:0] == RELEASE_ID
                 && r_out_data.packed_version[11:4] <= 8'd26))
        else $error("malformed good result");

    // The final character returns the parse state to reset values
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.last_byte)
            |=> (r_section == SEC_MAJOR && r_error == ERR_OK && !r_stopped
                 && r_acc == '0 && r_patch == '0))
        else $error("parse state not cleared after final character");

    // The first error sticks until the end of the string
    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ERR_OK && !(in_accept && i_in_data.last_byte))
            |=> (r_error == $past(r_error)))
        else $error("sticky error changed mid-string");
`endif

endmodule

### hw/rtl/vsp_byte_step.sv
// ============================================================================
// vsp_byte_step - per-character parse logic
// Combinational next state for one character, plus the final checks and
// word packing used when the character ends the string.
// ============================================================================
module vsp_byte_step #(
    parameter int unsigned COMPONENT_LIMIT = 256,
    parameter int unsigned ACC_W           = 9
) (
    input  logic [7:0]            i_char,
    input  logic [1:0]            i_section,
    input  logic [2:0][ACC_W-1:0] i_acc,
    input  logic [4:0]            i_patch,
    input  logic                  i_stopped,
    input  logic [2:0]            i_error,
    output logic [1:0]            o_section,
    output logic [2:0][ACC_W-1:0] o_acc,
    output logic [4:0]            o_patch,
    output logic                  o_stopped,
    output logic [2:0]            o_error,
    output vsp_pkg::t_out_item    o_result
);
    import vsp_pkg::*;

    localparam int unsigned SUM_W = ACC_W + 4;

    logic [1:0]       acc_idx;
    logic [SUM_W-1:0] sum;
    logic [7:0]       folded;
    logic             is_digit;
    logic             is_letter;
    logic             over_byte;
    logic [2:0]       fin_error;

    // Section 3 keeps adding digits to the fix part
    assign acc_idx  = (i_section == SEC_PATCH) ? SEC_FIX : i_section;
    assign sum      = (SUM_W'(i_acc[acc_idx]) << 3) + (SUM_W'(i_acc[acc_idx]) << 1)
                    + SUM_W'(i_char - CH_ZERO);
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign folded    = i_char | CASE_FOLD_BIT;
    assign is_letter = (folded >= CH_LOWER_A) && (folded <= CH_LOWER_Z);

    always_comb begin
        o_section = i_section;
        o_acc     = i_acc;
        o_patch   = i_patch;
        o_stopped = i_stopped;
        o_error   = i_error;
        if (i_error == ERR_OK && !i_stopped) begin
            if (i_char < CH_FIRST_PRINT || i_char > CH_LAST_PRINT) begin
                o_stopped = 1'b1;
            end else if (is_digit) begin
                if (sum > SUM_W'(COMPONENT_LIMIT)) begin
                    o_error = ERR_OVER_LIMIT;
                end else begin
                    o_acc[acc_idx] = sum[ACC_W-1:0];
                end
            end else if (i_char == CH_DOT) begin
                if (i_section < SEC_FIX) begin
                    o_section = i_section + 2'd1;
                end else begin
                    o_error = ERR_MANY_DOTS;
                end
            end else if (i_section < SEC_FIX) begin
                o_error = ERR_MISSING;
            end else if (i_section == SEC_PATCH) begin
                o_error = ERR_BAD_PATCH;
            end else begin
                o_section = SEC_PATCH;
                if (is_letter) begin
                    o_patch = 5'(folded - CH_LOWER_A + 8'd1);
                end else begin
                    o_error = ERR_NOT_LETTER;
                end
            end
        end
    end

    assign over_byte = (o_acc[SEC_MAJOR] > ACC_W'(BYTE_MAX))
                    || (o_acc[SEC_MINOR] > ACC_W'(BYTE_MAX))
                    || (o_acc[SEC_FIX]   > ACC_W'(BYTE_MAX));

    always_comb begin
        fin_error = o_error;
        if (o_error == ERR_OK) begin
            if (o_section < SEC_FIX) begin
                fin_error = ERR_TOO_SHORT;
            end else if (over_byte) begin
                fin_error = ERR_OVER_BYTE;
            end
        end
    end

    always_comb begin
        o_result.error_code     = fin_error;
        o_result.packed_version = '0;
        if (fin_error == ERR_OK) begin
            o_result.packed_version = {o_acc[SEC_MAJOR][7:0], o_acc[SEC_MINOR][7:0],
                                       o_acc[SEC_FIX][7:0], 3'b000, o_patch, RELEASE_ID};
        end
    end

endmodule
